// ===== design/esd_pkg.sv =====
// Shared types and constants for the escape sequence decoder.
`timescale 1ns / 1ps

package esd_pkg;

  localparam int CP_W    = 32;  // code point width
  localparam int Q_DEPTH = 4;   // result queue entries
  localparam int Q_IDX_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // One result item.
  typedef struct packed {
    logic [CP_W-1:0] out_char;
    logic            bad_escape;
    logic            last_out;
  } res_t;

  // Results produced by one accepted input item.
  typedef struct packed {
    logic [1:0] n_res;  // 0, 1 or 2
    res_t       res0;
    res_t       res1;
  } dec_out_t;

endpackage

// ===== design/esd_in_if.sv =====
// Input channel: code point and end-of-text marker.
`timescale 1ns / 1ps

interface esd_in_if import esd_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CP_W-1:0] code_point;
  logic            end_of_text;

  modport source (output valid, output code_point, output end_of_text, input ready);
  modport sink (input valid, input code_point, input end_of_text, output ready);
endinterface

// ===== design/esd_out_if.sv =====
// Result channel: decoded character, error flag and last marker.
`timescale 1ns / 1ps

interface esd_out_if import esd_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CP_W-1:0] out_char;
  logic            bad_escape;
  logic            last_out;

  modport source (output valid, output out_char, output bad_escape, output last_out,
                  input ready);
  modport sink (input valid, input out_char, input bad_escape, input last_out,
                output ready);
endinterface

// ===== design/esd_decode.sv =====
// Escape decoding state and per-item result logic.
`timescale 1ns / 1ps

module esd_decode import esd_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            fire,
  input  logic [CP_W-1:0] code_point,
  input  logic            end_of_text,
  output dec_out_t        dec
);

  typedef enum logic [2:0] {
    M_NORMAL = 3'd0,
    M_ESC    = 3'd1,
    M_HEX    = 3'd2,
    M_OCT    = 3'd3,
    M_UNI    = 3'd4
  } mode_t;

  localparam logic [CP_W-1:0] CH_NUL    = 32'h00;
  localparam logic [CP_W-1:0] CH_SQUOTE = 32'h27;
  localparam logic [CP_W-1:0] CH_DQUOTE = 32'h22;
  localparam logic [CP_W-1:0] CH_QMARK  = 32'h3F;
  localparam logic [CP_W-1:0] BACKSLASH = 32'h5C;
  localparam logic [CP_W-1:0] CH_A      = 32'h61;
  localparam logic [CP_W-1:0] CH_B      = 32'h62;
  localparam logic [CP_W-1:0] CH_E      = 32'h65;
  localparam logic [CP_W-1:0] CH_F      = 32'h66;
  localparam logic [CP_W-1:0] CH_N      = 32'h6E;
  localparam logic [CP_W-1:0] CH_R      = 32'h72;
  localparam logic [CP_W-1:0] CH_T      = 32'h74;
  localparam logic [CP_W-1:0] CH_V      = 32'h76;
  localparam logic [CP_W-1:0] CH_X      = 32'h78;
  localparam logic [CP_W-1:0] CH_ZERO   = 32'h30;
  localparam logic [CP_W-1:0] CH_LC_U   = 32'h75;
  localparam logic [CP_W-1:0] CH_UC_U   = 32'h55;
  localparam logic [CP_W-1:0] ESC_CHAR  = 32'h1B;

  mode_t           mode_r, mode_nxt;
  logic [CP_W-1:0] acc_r, acc_nxt;
  logic [3:0]      dleft_r, dleft_nxt;
  logic            anul_r, anul_nxt;

  logic            is_hex, is_oct;
  logic [3:0]      hv;
  logic [3:0]      dleft_dec;
  logic [CP_W-1:0] acc_sh4, acc_sh3;
  logic            pre_v, pre_b, norm_v, fin_v, fin_b, run_norm;
  logic [CP_W-1:0] pre_c, fin_c;
  res_t            pre_res, norm_res, fin_res;
  logic [1:0]      n_raw;

  always_comb begin
    is_hex = 1'b0;
    hv     = code_point[3:0];
    if (code_point >= 32'h30 && code_point <= 32'h39) begin
      is_hex = 1'b1;
    end else if ((code_point >= 32'h61 && code_point <= 32'h66) ||
                 (code_point >= 32'h41 && code_point <= 32'h46)) begin
      is_hex = 1'b1;
      hv     = code_point[3:0] + 4'd9;
    end
    is_oct    = (code_point >= 32'h30 && code_point <= 32'h37);
    acc_sh4   = {acc_r[CP_W-5:0], hv};
    acc_sh3   = {acc_r[CP_W-4:0], code_point[2:0]};
    dleft_dec = dleft_r - 4'd1;
  end

  always_comb begin
    mode_nxt  = mode_r;
    acc_nxt   = acc_r;
    dleft_nxt = dleft_r;
    anul_nxt  = anul_r;
    pre_v     = 1'b0;
    pre_c     = '0;
    pre_b     = 1'b0;
    run_norm  = 1'b0;
    norm_v    = 1'b0;
    fin_v     = 1'b0;
    fin_c     = '0;
    fin_b     = 1'b0;

    // Mode-specific handling of the character
    case (mode_r)
      M_NORMAL: begin
        run_norm = 1'b1;
      end
      M_ESC: begin
        mode_nxt = M_NORMAL;
        case (code_point)
          CH_SQUOTE, CH_DQUOTE, CH_QMARK, BACKSLASH: begin
            pre_v = 1'b1;
            pre_c = code_point;
          end
          CH_A: begin pre_v = 1'b1; pre_c = 32'h07; end
          CH_B: begin pre_v = 1'b1; pre_c = 32'h08; end
          CH_F: begin pre_v = 1'b1; pre_c = 32'h0C; end
          CH_N: begin pre_v = 1'b1; pre_c = 32'h0A; end
          CH_R: begin pre_v = 1'b1; pre_c = 32'h0D; end
          CH_T: begin pre_v = 1'b1; pre_c = 32'h09; end
          CH_V: begin pre_v = 1'b1; pre_c = 32'h0B; end
          CH_E: begin pre_v = 1'b1; pre_c = ESC_CHAR; end
          CH_X: begin
            mode_nxt = M_HEX;
            acc_nxt  = '0;
          end
          CH_ZERO: begin
            mode_nxt = M_OCT;
            acc_nxt  = '0;
          end
          CH_LC_U: begin
            mode_nxt  = M_UNI;
            acc_nxt   = '0;
            dleft_nxt = 4'd4;
          end
          CH_UC_U: begin
            mode_nxt  = M_UNI;
            acc_nxt   = '0;
            dleft_nxt = 4'd8;
          end
          default: begin
            // unknown escape: drop the backslash
            run_norm = 1'b1;
          end
        endcase
      end
      M_HEX: begin
        if (is_hex) begin
          acc_nxt = acc_sh4;
        end else begin
          pre_v    = 1'b1;
          pre_c    = acc_r;
          mode_nxt = M_NORMAL;
          run_norm = 1'b1;
        end
      end
      M_OCT: begin
        if (is_oct) begin
          acc_nxt = acc_sh3;
        end else begin
          pre_v    = 1'b1;
          pre_c    = acc_r;
          mode_nxt = M_NORMAL;
          run_norm = 1'b1;
        end
      end
      M_UNI: begin
        if (is_hex) begin
          acc_nxt   = acc_sh4;
          dleft_nxt = dleft_dec;
          if (dleft_dec == 4'd0) begin
            pre_v    = 1'b1;
            pre_c    = acc_sh4;
            mode_nxt = M_NORMAL;
          end
        end else begin
          pre_v     = 1'b1;
          pre_b     = 1'b1;
          mode_nxt  = M_NORMAL;
          dleft_nxt = 4'd0;
          run_norm  = 1'b1;
        end
      end
      default: begin
        mode_nxt = M_NORMAL;
        run_norm = 1'b1;
      end
    endcase

    // Plain character handling
    if (run_norm) begin
      if (anul_r) begin
        norm_v = 1'b1;
      end else if (code_point == BACKSLASH) begin
        mode_nxt = M_ESC;
      end else begin
        norm_v = 1'b1;
        if (code_point == CH_NUL) begin
          anul_nxt = 1'b1;
        end
      end
    end

    // End of string: flush a pending escape, then return to reset state
    if (end_of_text) begin
      if (mode_nxt == M_HEX || mode_nxt == M_OCT) begin
        fin_v = 1'b1;
        fin_c = acc_nxt;
      end else if (mode_nxt == M_ESC || mode_nxt == M_UNI) begin
        fin_v = 1'b1;
        fin_b = 1'b1;
      end
      mode_nxt  = M_NORMAL;
      acc_nxt   = '0;
      dleft_nxt = 4'd0;
      anul_nxt  = 1'b0;
    end
  end

  // Compact up to two results
  always_comb begin
    pre_res  = '{out_char: pre_c, bad_escape: pre_b, last_out: 1'b0};
    norm_res = '{out_char: code_point, bad_escape: 1'b0, last_out: 1'b0};
    fin_res  = '{out_char: fin_c, bad_escape: fin_b, last_out: 1'b0};
    n_raw    = 2'({1'b0, pre_v} + {1'b0, norm_v} + {1'b0, fin_v});
    dec.n_res = (n_raw > 2'd2) ? 2'd2 : n_raw;
    dec.res0  = pre_v ? pre_res : (norm_v ? norm_res : fin_res);
    dec.res1  = (pre_v && norm_v) ? norm_res : fin_res;
    if (end_of_text) begin
      if (dec.n_res == 2'd2) begin
        dec.res1.last_out = 1'b1;
      end else begin
        dec.res0.last_out = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_NORMAL;
      acc_r   <= '0;
      dleft_r <= 4'd0;
      anul_r  <= 1'b0;
    end else if (fire) begin
      mode_r  <= mode_nxt;
      acc_r   <= acc_nxt;
      dleft_r <= dleft_nxt;
      anul_r  <= anul_nxt;
    end
  end

  a_eot_resets: assert property (@(posedge clk) disable iff (!rst_n)
    fire && end_of_text |=> mode_r == M_NORMAL && acc_r == '0 && !anul_r)
    else $error("state not cleared after end of text");

  a_eot_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire && end_of_text |-> dec.n_res != 2'd0)
    else $error("final item produced no result");

  a_uni_count: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == M_UNI |-> dleft_r != 4'd0 && dleft_r <= 4'd8)
    else $error("unicode digit count out of range");

endmodule

// ===== design/esd_res_q.sv =====
// Result queue between the decoder and the result channel.
`timescale 1ns / 1ps

module esd_res_q import esd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     fire,
  input  dec_out_t dec,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output res_t     head
);

  res_t               q_r [Q_DEPTH];
  logic [Q_IDX_W-1:0] wp_r, rp_r;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]         n_push;
  logic               pop;
  logic [Q_IDX_W-1:0] wp_inc;

  assign n_push    = fire ? dec.n_res : 2'd0;
  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && out_ready;
  // room for two results keeps every item's output in one push
  assign in_ready  = (cnt_r <= Q_CNT_W'(Q_DEPTH - 2));
  assign head      = q_r[rp_r];
  assign wp_inc    = wp_r + Q_IDX_W'(1);
  assign cnt_nxt   = cnt_r + Q_CNT_W'(n_push) - Q_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      q_r[wp_r] <= dec.res0;
    end
    if (n_push == 2'd2) begin
      q_r[wp_inc] <= dec.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + Q_IDX_W'(n_push);
      rp_r  <= rp_r + Q_IDX_W'(pop);
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= Q_CNT_W'(Q_DEPTH))
    else $error("result queue overflow");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    Q_IDX_W'(wp_r - rp_r) == cnt_r[Q_IDX_W-1:0])
    else $error("queue pointers disagree with fill count");

endmodule

// ===== design/escape_sequence_decoder_top.sv =====
// Top level of the C-style escape sequence decoder.
`timescale 1ns / 1ps

//  channel   dir   handshake            payload
//  in_ch     in    valid/ready          code_point[31:0], end_of_text
//  out_ch    out   valid/ready          out_char[31:0], bad_escape, last_out
//
//  Each input item is decoded in the cycle it is accepted; its zero, one or
//  two results land in a four-entry result queue, which hands them to out_ch
//  in order. One item per cycle is sustained while out_ch.ready is high and
//  each item yields at most one result; an item that yields two (a digit run
//  cut short by the next character) drains one result at a time through the
//  single read port of the queue. in_ch.ready is high while the queue has
//  room for two results, so input is taken while results wait. Reset is
//  synchronous and puts the decoder in plain text mode with an empty queue.

module escape_sequence_decoder_top import esd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  esd_in_if.sink    in_ch,
  esd_out_if.source out_ch
);

  dec_out_t dec;
  res_t     head;
  logic     fire;
  logic     q_ready;

  // accept an item when the queue can hold everything it produces
  assign in_ch.ready = q_ready;
  assign fire        = in_ch.valid && q_ready;

  // decode the item against the current escape state
  esd_decode u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .code_point  (in_ch.code_point),
    .end_of_text (in_ch.end_of_text),
    .dec         (dec)
  );

  // hold results until the sink takes them
  esd_res_q u_res_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .dec       (dec),
    .in_ready  (q_ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .head      (head)
  );

  assign out_ch.out_char   = head.out_char;
  assign out_ch.bad_escape = head.bad_escape;
  assign out_ch.last_out   = head.last_out;

endmodule

// ===== verif/esd_decode_checker.sv =====
// Watches both channels of the escape sequence decoder, predicts its results and compares them.
`timescale 1ns / 1ps

module esd_decode_checker import esd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  esd_in_if    in_mon,
  esd_out_if   out_mon,
  output int   fail_count,
  output int   pending
);

  typedef enum logic [2:0] {
    MODE_TEXT,
    MODE_ESC,
    MODE_HEX,
    MODE_OCT,
    MODE_UNI
  } dec_mode_t;

  localparam logic [31:0] CH_BSLASH = 32'h5C;
  localparam logic [31:0] CH_SQUOTE = 32'h27;
  localparam logic [31:0] CH_DQUOTE = 32'h22;
  localparam logic [31:0] CH_QMARK  = 32'h3F;
  localparam logic [31:0] CH_A      = 32'h61;
  localparam logic [31:0] CH_B      = 32'h62;
  localparam logic [31:0] CH_F      = 32'h66;
  localparam logic [31:0] CH_N      = 32'h6E;
  localparam logic [31:0] CH_R      = 32'h72;
  localparam logic [31:0] CH_T      = 32'h74;
  localparam logic [31:0] CH_V      = 32'h76;
  localparam logic [31:0] CH_E      = 32'h65;
  localparam logic [31:0] CH_X      = 32'h78;
  localparam logic [31:0] CH_ZERO   = 32'h30;
  localparam logic [31:0] CH_SEVEN  = 32'h37;
  localparam logic [31:0] CH_U4     = 32'h75;
  localparam logic [31:0] CH_U8     = 32'h55;
  localparam logic [31:0] ESC_CODE  = 32'h1B;

  // Decoder state as predicted.
  dec_mode_t   mode;
  logic [31:0] acc;
  logic [3:0]  owed;
  logic        nul_seen;

  res_t step_res [2];
  int   step_n;
  res_t pending_results [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic int hex_val(input logic [31:0] c);
    if (c >= 32'h30 && c <= 32'h39) return int'(c - 32'h30);
    if (c >= 32'h61 && c <= 32'h66) return int'(c - 32'h61 + 10);
    if (c >= 32'h41 && c <= 32'h46) return int'(c - 32'h41 + 10);
    return -1;
  endfunction

  task automatic clear_state();
    mode     = MODE_TEXT;
    acc      = '0;
    owed     = '0;
    nul_seen = 1'b0;
  endtask

  task automatic add_res(input logic [31:0] ch, input logic bad);
    if (step_n < 2) begin
      step_res[step_n] = '{out_char: ch, bad_escape: bad, last_out: 1'b0};
      step_n++;
    end
  endtask

  task automatic take_plain(input logic [31:0] c);
    if (nul_seen) begin
      add_res(c, 1'b0);
    end else if (c == CH_BSLASH) begin
      mode = MODE_ESC;
    end else begin
      add_res(c, 1'b0);
      if (c == '0) nul_seen = 1'b1;
    end
  endtask

  task automatic take_escape(input logic [31:0] c);
    mode = MODE_TEXT;
    case (c)
      CH_SQUOTE, CH_DQUOTE, CH_QMARK, CH_BSLASH: add_res(c, 1'b0);
      CH_A: add_res(32'h07, 1'b0);
      CH_B: add_res(32'h08, 1'b0);
      CH_F: add_res(32'h0C, 1'b0);
      CH_N: add_res(32'h0A, 1'b0);
      CH_R: add_res(32'h0D, 1'b0);
      CH_T: add_res(32'h09, 1'b0);
      CH_V: add_res(32'h0B, 1'b0);
      CH_E: add_res(ESC_CODE, 1'b0);
      CH_X: begin
        mode = MODE_HEX;
        acc  = '0;
      end
      CH_ZERO: begin
        mode = MODE_OCT;
        acc  = '0;
      end
      CH_U4: begin
        mode = MODE_UNI;
        acc  = '0;
        owed = 4'd4;
      end
      CH_U8: begin
        mode = MODE_UNI;
        acc  = '0;
        owed = 4'd8;
      end
      // unknown escape: drop the backslash
      default: take_plain(c);
    endcase
  endtask

  task automatic decode_item(input logic [31:0] c, input logic eot);
    int h;
    h      = hex_val(c);
    step_n = 0;
    case (mode)
      MODE_ESC: take_escape(c);
      MODE_HEX: begin
        if (h >= 0) begin
          acc = {acc[27:0], h[3:0]};
        end else begin
          add_res(acc, 1'b0);
          mode = MODE_TEXT;
          take_plain(c);
        end
      end
      MODE_OCT: begin
        if (c >= CH_ZERO && c <= CH_SEVEN) begin
          acc = {acc[28:0], c[2:0]};
        end else begin
          add_res(acc, 1'b0);
          mode = MODE_TEXT;
          take_plain(c);
        end
      end
      MODE_UNI: begin
        if (h >= 0) begin
          acc  = {acc[27:0], h[3:0]};
          owed = owed - 4'd1;
          if (owed == '0) begin
            add_res(acc, 1'b0);
            mode = MODE_TEXT;
          end
        end else begin
          add_res('0, 1'b1);
          mode = MODE_TEXT;
          owed = '0;
          take_plain(c);
        end
      end
      default: begin
        mode = MODE_TEXT;
        take_plain(c);
      end
    endcase
    if (eot) begin
      if (mode == MODE_HEX || mode == MODE_OCT) add_res(acc, 1'b0);
      else if (mode == MODE_ESC || mode == MODE_UNI) add_res('0, 1'b1);
      if (step_n > 0) step_res[step_n-1].last_out = 1'b1;
      clear_state();
    end
    for (int i = 0; i < step_n; i++) pending_results.push_back(step_res[i]);
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      clear_state();
      pending_results.delete();
    end else begin
      // results leaving now stem from items taken at earlier edges
      if (out_mon.valid && out_mon.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result %h with none outstanding", out_mon.out_char));
        end else begin
          want = pending_results.pop_front();
          if (out_mon.out_char !== want.out_char)
            report_mismatch($sformatf("out_char %h, want %h", out_mon.out_char,
                                      want.out_char));
          if (out_mon.bad_escape !== want.bad_escape)
            report_mismatch($sformatf("bad_escape %b, want %b", out_mon.bad_escape,
                                      want.bad_escape));
          if (out_mon.last_out !== want.last_out)
            report_mismatch($sformatf("last_out %b, want %b", out_mon.last_out,
                                      want.last_out));
        end
      end
      if (in_mon.valid && in_mon.ready) decode_item(in_mon.code_point, in_mon.end_of_text);
    end
    pending <= pending_results.size();
  end

endmodule

// ===== verif/tb_escape_sequence_decoder_top.sv =====
// Stimulus, clock, reset and verdict for the escape sequence decoder.
`timescale 1ns / 1ps

module tb_escape_sequence_decoder_top;
  import esd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;  // slowest legal run is far below this
  localparam int PHASE_ITEMS = 440;     // four phases, about 1750 items
  localparam int LONG_HOLD   = 300;     // receiver hold-off that fills the result queue
  localparam int DRAIN_WAIT  = 20;

  localparam logic [31:0] CH_BSLASH = 32'h5C;
  localparam logic [31:0] CH_X      = 32'h78;
  localparam logic [31:0] CH_ZERO   = 32'h30;
  localparam logic [31:0] CH_U4     = 32'h75;
  localparam logic [31:0] CH_U8     = 32'h55;
  localparam logic [31:0] CH_ONE    = 32'h31;

  // Second characters of every simple escape.
  localparam logic [31:0] SIMPLE_ESC [12] = '{
    32'h27, 32'h22, 32'h3F, 32'h5C, 32'h61, 32'h62,
    32'h66, 32'h6E, 32'h72, 32'h74, 32'h76, 32'h65
  };
  // Characters at and just outside the digit range edges, plus wide ones.
  localparam logic [31:0] EDGE_CHARS [14] = '{
    32'h2F, 32'h3A, 32'h40, 32'h47, 32'h60, 32'h67, 32'h38,
    32'h39, 32'h46, 32'h66, 32'h41, 32'h61, 32'h0010_0030, 32'hFFFF_FF61
  };
  // None of these is a hex digit.
  localparam logic [31:0] NON_HEX [10] = '{
    32'h2F, 32'h3A, 32'h40, 32'h47, 32'h60, 32'h67,
    32'h5C, 32'h00, 32'h7A, 32'h0010_0030
  };

  logic clk = 1'b0;
  logic rst_n;

  esd_in_if  in_ch ();
  esd_out_if out_ch ();

  int fail_cnt;
  int pend_cnt;

  escape_sequence_decoder_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  esd_decode_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_cnt),
    .pending    (pend_cnt)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop: nothing legal takes this long.
  int cycle_cnt = 0;
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Idle knobs. idle_pct is used by the sender only; stall_pct is read by the
  // receiver at clock edges, so update it with nonblocking writes.
  int idle_pct  = 0;
  int stall_pct = 0;
  int hold_reqs = 0;

  // Receiver: stall at random; on each new hold request, keep ready low for a
  // long stretch counted here, so the queue fills and in_ch.ready drops.
  initial begin
    int hold_done;
    hold_done    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_reqs != hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done++;
      end
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Characters of the string being built; the last one carries end_of_text.
  logic [31:0] text_q [$];

  // Offer one item and hold it until taken; idle gaps go in front of it.
  task automatic send_item(input logic [31:0] cp, input logic eot);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.code_point  <= cp;
    in_ch.end_of_text <= eot;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) send_item(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  function automatic logic [31:0] rand_hex_digit();
    int r;
    r = $urandom_range(21);
    if (r < 10) return 32'h30 + r;
    if (r < 16) return 32'h61 + r - 10;
    return 32'h41 + r - 16;
  endfunction

  function automatic logic [31:0] noise_char();
    case ($urandom_range(3))
      0: return $urandom();
      1: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
      2: return EDGE_CHARS[$urandom_range(13)];
      default: return ($urandom() & 32'hFFFF_FF00) | (32'h30 + $urandom_range(15));
    endcase
  endfunction

  task automatic push_hex(input int n);
    repeat (n) text_q.push_back(rand_hex_digit());
  endtask

  task automatic push_oct(input int n);
    repeat (n) text_q.push_back(CH_ZERO + $urandom_range(7));
  endtask

  // Append one piece of text: mostly well-formed escapes with random content,
  // the rest plain characters, unknown or broken escapes, NULs and noise.
  task automatic add_token();
    int kind;
    int n;
    kind = $urandom_range(99);
    if (kind < 20) begin
      text_q.push_back(32'h20 + $urandom_range(94));
    end else if (kind < 35) begin
      text_q.push_back(CH_BSLASH);
      text_q.push_back(SIMPLE_ESC[$urandom_range(11)]);
    end else if (kind < 45) begin
      // long runs now and then, so the accumulator wraps
      n = ($urandom_range(9) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 4);
      text_q.push_back(CH_BSLASH);
      text_q.push_back(CH_X);
      push_hex(n);
    end else if (kind < 53) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(11, 13) : $urandom_range(0, 4);
      text_q.push_back(CH_BSLASH);
      text_q.push_back(CH_ZERO);
      push_oct(n);
    end else if (kind < 63) begin
      text_q.push_back(CH_BSLASH);
      text_q.push_back(CH_U4);
      push_hex(4);
    end else if (kind < 70) begin
      text_q.push_back(CH_BSLASH);
      text_q.push_back(CH_U8);
      push_hex(8);
    end else if (kind < 77) begin
      text_q.push_back(CH_BSLASH);
      case ($urandom_range(3))
        0: text_q.push_back(CH_ONE + $urandom_range(6));
        1: text_q.push_back(32'h0);
        2: text_q.push_back(32'h20 + $urandom_range(94));
        default: text_q.push_back(noise_char());
      endcase
    end else if (kind < 83) begin
      // unicode escape broken by a non-digit before it is complete
      text_q.push_back(CH_BSLASH);
      if ($urandom_range(1)) begin
        text_q.push_back(CH_U4);
        push_hex($urandom_range(3));
      end else begin
        text_q.push_back(CH_U8);
        push_hex($urandom_range(7));
      end
      text_q.push_back(NON_HEX[$urandom_range(9)]);
    end else if (kind < 88) begin
      text_q.push_back(32'h0);
    end else begin
      text_q.push_back(noise_char());
    end
  endtask

  // Build one random string, now and then cut off inside an escape.
  task automatic build_string();
    repeat ($urandom_range(1, 8)) add_token();
    if ($urandom_range(99) < 12) begin
      text_q.push_back(CH_BSLASH);
      case ($urandom_range(3))
        0: ;
        1: begin
          text_q.push_back(CH_U4);
          push_hex($urandom_range(3));
        end
        2: begin
          text_q.push_back(CH_U8);
          push_hex($urandom_range(7));
        end
        default: begin
          if ($urandom_range(1)) begin
            text_q.push_back(CH_X);
            push_hex($urandom_range(3));
          end else begin
            text_q.push_back(CH_ZERO);
            push_oct($urandom_range(3));
          end
        end
      endcase
    end
  endtask

  initial begin
    int sent;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.code_point  = '0;
    in_ch.end_of_text = 1'b0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed strings.
    // widest code point, unknown escape of a NUL, then literal pass-through
    text_q = '{32'hFFFF_FFFF, CH_BSLASH, 32'h0, CH_BSLASH, 32'h6E};
    send_text();
    // empty hex run ended by a non-digit: two results in one step
    text_q = '{CH_BSLASH, CH_X, 32'h47};
    send_text();
    // exact four-digit unicode escape
    text_q = '{CH_BSLASH, CH_U4, 32'h41, 32'h62, 32'h30, 32'h39};
    send_text();
    // bad unicode digit, the character then taken as text
    text_q = '{CH_BSLASH, CH_U4, 32'h31, 32'h7A};
    send_text();
    // octal run ended by a non-octal digit
    text_q = '{CH_BSLASH, CH_ZERO, 32'h37, 32'h37, 32'h38};
    send_text();
    // end right after a backslash
    text_q = '{CH_BSLASH};
    send_text();
    // only backslash zero starts octal; backslash one is unknown
    text_q = '{CH_BSLASH, CH_ONE};
    send_text();
    // end inside an eight-digit unicode escape
    text_q = '{CH_BSLASH, CH_U8, 32'h46};
    send_text();
    // hex run completed by the end of the string
    text_q = '{CH_BSLASH, CH_X, 32'h66, 32'h46};
    send_text();

    // Random phases: no idling (with one long receiver hold-off), sender
    // mostly idle, receiver mostly stalled, both idling now and then.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct  = 0;
          stall_pct <= 0;
          hold_reqs <= hold_reqs + 1;
        end
        1: begin
          idle_pct  = 87;
          stall_pct <= 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct <= 87;
        end
        default: begin
          idle_pct  = 22;
          stall_pct <= 22;
        end
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        build_string();
        sent += text_q.size();
        send_text();
      end
    end

    // Drop valid, let every outstanding result arrive, then linger a little
    // to catch any extra result.
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pend_cnt != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
